FILE: rtl/dprm_pkg.sv
package dprm_pkg;

    localparam int WINDOW_DEPTH_DEF = 64;
    localparam int SAMPLE_BITS_DEF  = 12;
    localparam int RMS_INTERVAL_DEF = 16;

    localparam int REG_GAIN_MULT  = 0;
    localparam int REG_GAIN_OFS   = 1;
    localparam int REG_CAL_EN     = 2;
    localparam int REG_REF_MV     = 3;
    localparam int REG_FULL_SCALE = 4;

    localparam logic [15:0] GAIN_MULT_RST  = 16'd1024;
    localparam logic [15:0] REF_MV_RST     = 16'd3300;
    localparam logic [15:0] FULL_SCALE_RST = 16'd4095;

    localparam int FILT_BITS = 24;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture sample, write window, update running peak
        logic sum_clr;
        logic sum_acc;    // accumulate square of read entry
        logic peak_clr;
        logic peak_scan;  // compare read entry against peak
        logic div_start;  // sum*65536/n
        logic sqrt_start;
        logic mul_start;  // r*ref
        logic scl_start;  // /fs
        logic flt_start;  // filter
        logic flt_step;
        logic finish;     // advance pointer, form result
    } dprm_cmd_t;

    typedef struct packed {
        logic busy;       // iterative unit running
        logic rms_due;
        logic wrap;
    } dprm_sts_t;

endpackage

FILE: rtl/dprm_ctrl.sv
module dprm_ctrl
    import dprm_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_fire,
    input  logic                            out_free,
    input  dprm_sts_t                       sts,
    input  logic [$clog2(WINDOW_DEPTH):0]   n_cnt,
    output dprm_cmd_t                       cmd,
    output logic [$clog2(WINDOW_DEPTH)-1:0] rd_addr,
    output logic                            idle
);

    localparam int AW = $clog2(WINDOW_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE, S_SUM, S_SUMW, S_DIV, S_SQRT, S_MUL, S_SCL, S_FLT,
        S_FIN, S_SCAN, S_SCANW, S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic [AW:0] cnt_reg, cnt_next;
    logic        go_reg, go_next;

    assign idle    = (state_reg == S_IDLE);
    assign rd_addr = cnt_reg[AW-1:0];

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        go_next    = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.load  = 1'b1;
                    cmd.sum_clr = 1'b1;
                    cnt_next  = '0;
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                if (!sts.rms_due)
                    state_next = S_FIN;
                else if (cnt_reg == n_cnt)
                    state_next = S_SUMW;
                else
                    cnt_next = cnt_reg + 1'b1;
                cmd.sum_acc = (cnt_reg != '0) && sts.rms_due;
            end
            S_SUMW:
            begin
                cmd.div_start = 1'b1;
                go_next = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (!go_reg && !sts.busy)
                begin
                    cmd.sqrt_start = 1'b1;
                    go_next = 1'b1;
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                if (!go_reg && !sts.busy)
                begin
                    cmd.mul_start = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.scl_start = 1'b1;
                go_next = 1'b1;
                state_next = S_SCL;
            end
            S_SCL:
            begin
                if (!go_reg && !sts.busy)
                begin
                    cmd.flt_start = 1'b1;
                    go_next = 1'b1;
                    state_next = S_FLT;
                end
            end
            S_FLT:
            begin
                if (!go_reg && !sts.busy)
                begin
                    cmd.flt_step = 1'b1;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (sts.wrap)
                begin
                    cmd.peak_clr = 1'b1;
                    cnt_next = '0;
                    state_next = S_SCAN;
                end
                else if (out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                cmd.peak_scan = (cnt_reg != '0);
                if (cnt_reg == (AW+1)'(WINDOW_DEPTH))
                    state_next = S_SCANW;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_SCANW:
            begin
                cmd.peak_scan = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            go_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            go_reg    <= go_next;
        end
    end

`ifndef SYNTHESIS
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> idle) else $error("load outside idle");
    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> out_free) else $error("finish without room");
    a_fin_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> idle) else $error("no return to idle");
`endif

endmodule

FILE: rtl/dprm_dp.sv
module dprm_dp
    import dprm_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
    parameter int RMS_INTERVAL = RMS_INTERVAL_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [SAMPLE_BITS-1:0]          sample_pos,
    input  logic [SAMPLE_BITS-1:0]          sample_neg,
    input  dprm_cmd_t                       cmd,
    input  logic [$clog2(WINDOW_DEPTH)-1:0] rd_addr,
    input  logic [15:0]                     gain_mult,
    input  logic [15:0]                     gain_ofs,
    input  logic                            cal_en,
    input  logic [15:0]                     ref_mv,
    input  logic [15:0]                     full_scale,
    output dprm_sts_t                       sts,
    output logic [$clog2(WINDOW_DEPTH):0]   n_cnt,
    output logic [SAMPLE_BITS-1:0]          peak_raw,
    output logic [15:0]                     peak_cal,
    output logic [15:0]                     rms_mv,
    output logic                            rms_valid,
    output logic                            rms_updated
);

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int CW = (RMS_INTERVAL > 1) ? $clog2(RMS_INTERVAL) : 1;
    localparam int SQW = 2 * SAMPLE_BITS;
    localparam int SW  = SQW + AW + 1;
    localparam int NW  = SW + 16;          // dividend sum<<16
    localparam int RW  = (NW + 1) / 2;      // root width
    localparam int PW  = RW + 16;           // r*ref
    localparam int MW  = 64;
    localparam int DCW = $clog2(MW + 1);
    localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;  // x/10 = (x*recip)>>35

    logic [SAMPLE_BITS-1:0] mem [WINDOW_DEPTH];
    logic [SAMPLE_BITS-1:0] rd_reg;
    logic [AW-1:0]          wp_reg;
    logic                   full_reg;
    logic [SAMPLE_BITS-1:0] peak_reg;
    logic [CW-1:0]          icnt_reg;
    logic                   due;
    logic                   due_reg;
    logic [SW-1:0]          sum_reg;
    logic [FILT_BITS-1:0]   filt_reg;
    logic                   seeded_reg;
    logic                   upd_reg;
    logic [SAMPLE_BITS-1:0] diff;

    // shared restoring divider: quo_reg = num / den
    logic [MW-1:0]  quo_reg, rem_reg, den_reg;
    logic [DCW-1:0] dcnt_reg;
    logic           sq_reg;
    logic [MW-1:0]  rootr_reg, rootx_reg, bit_reg;
    logic [PW-1:0]  prod_reg;
    logic [FILT_BITS+3:0] fsum;
    logic [FILT_BITS-1:0] vsat;
    logic [63:0]    dprod;
    logic [SW-1:0]  sq_ext;
    logic [MW:0]    trial;
    logic [MW-1:0]  rbit;

    assign diff   = (sample_pos >= sample_neg) ? sample_pos - sample_neg
                                               : sample_neg - sample_pos;
    assign n_cnt  = full_reg ? (AW+1)'(WINDOW_DEPTH) : {1'b0, wp_reg} + 1'b1;
    assign sq_ext = SW'(rd_reg * rd_reg);
    assign trial  = {rem_reg[MW-2:0], quo_reg[MW-1]} - {1'b0, den_reg};
    assign rbit   = rootr_reg + bit_reg;
    assign vsat   = (quo_reg > MW'({FILT_BITS{1'b1}})) ? {FILT_BITS{1'b1}}
                                                       : quo_reg[FILT_BITS-1:0];
    assign fsum   = (FILT_BITS+4)'(filt_reg) * 4'd9 + (FILT_BITS+4)'(vsat)
                    + (FILT_BITS+4)'(5);
    assign dprod  = rootx_reg[31:0] * DIV10_RECIP;

    assign due         = (icnt_reg == CW'(RMS_INTERVAL - 1)) || (RMS_INTERVAL == 1);
    assign sts.busy    = (dcnt_reg != '0) || (bit_reg != '0) || sq_reg;
    assign sts.rms_due = upd_reg;
    assign sts.wrap    = (wp_reg == AW'(WINDOW_DEPTH - 1));

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            mem[wp_reg] <= diff;
        rd_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sum_clr)
            sum_reg <= '0;
        else if (cmd.sum_acc)
            sum_reg <= sum_reg + sq_ext;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dcnt_reg  <= '0;
            bit_reg   <= '0;
            quo_reg   <= '0;
            rem_reg   <= '0;
            den_reg   <= '0;
            rootr_reg <= '0;
            rootx_reg <= '0;
            prod_reg  <= '0;
            sq_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.div_start)
            begin
                quo_reg  <= MW'({sum_reg, 16'h0});
                rem_reg  <= '0;
                den_reg  <= MW'(n_cnt);
                dcnt_reg <= DCW'(MW);
            end
            else if (cmd.scl_start)
            begin
                quo_reg  <= MW'(prod_reg);
                rem_reg  <= '0;
                den_reg  <= (full_scale == '0) ? MW'(1) : MW'(full_scale);
                dcnt_reg <= DCW'(MW);
            end
            else if (cmd.flt_start)
            begin
                if (seeded_reg)
                begin
                    rootx_reg <= MW'(fsum);
                    sq_reg    <= 1'b1;
                end
                else
                    quo_reg <= MW'(vsat);
            end
            else if (sq_reg)
            begin
                quo_reg <= MW'(dprod[63:35]);
                sq_reg  <= 1'b0;
            end
            else if (dcnt_reg != '0)
            begin
                dcnt_reg <= dcnt_reg - 1'b1;
                if (!trial[MW])
                begin
                    rem_reg <= trial[MW-1:0];
                    quo_reg <= {quo_reg[MW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= {rem_reg[MW-2:0], quo_reg[MW-1]};
                    quo_reg <= {quo_reg[MW-2:0], 1'b0};
                end
            end
            if (cmd.sqrt_start)
            begin
                rootx_reg <= quo_reg;
                rootr_reg <= '0;
                bit_reg   <= MW'(1) << (MW - 2);
            end
            else if (bit_reg != '0)
            begin
                if (rootx_reg >= rbit)
                begin
                    rootx_reg <= rootx_reg - rbit;
                    rootr_reg <= (rootr_reg >> 1) + bit_reg;
                end
                else
                    rootr_reg <= rootr_reg >> 1;
                bit_reg <= bit_reg >> 2;
            end
            if (cmd.mul_start)
                prod_reg <= PW'(rootr_reg[RW-1:0] * ref_mv);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg     <= '0;
            full_reg   <= 1'b0;
            peak_reg   <= '0;
            icnt_reg   <= '0;
            filt_reg   <= '0;
            seeded_reg <= 1'b0;
            upd_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                if (diff > peak_reg)
                    peak_reg <= diff;
                icnt_reg <= due ? '0 : icnt_reg + 1'b1;
                upd_reg  <= due;
            end
            if (cmd.peak_clr)
                peak_reg <= '0;
            else if (cmd.peak_scan && rd_reg > peak_reg)
                peak_reg <= rd_reg;
            if (cmd.flt_step)
            begin
                filt_reg   <= quo_reg[FILT_BITS-1:0];
                seeded_reg <= 1'b1;
            end
            if (cmd.finish)
            begin
                wp_reg <= sts.wrap ? '0 : wp_reg + 1'b1;
                if (sts.wrap)
                    full_reg <= 1'b1;
            end
        end
    end

    logic [SAMPLE_BITS+15:0] scaled;
    logic [SAMPLE_BITS+6:0]  shf;
    logic [FILT_BITS:0]      rnd;
    assign scaled = peak_reg * gain_mult;
    assign shf    = (SAMPLE_BITS+7)'(scaled[SAMPLE_BITS+15:10]);
    assign rnd    = {1'b0, filt_reg} + 9'd128;

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            peak_raw <= peak_reg;
            if (!cal_en)
                peak_cal <= 16'(peak_reg);
            else if (shf < (SAMPLE_BITS+7)'(gain_ofs))
                peak_cal <= '0;
            else if (shf - (SAMPLE_BITS+7)'(gain_ofs) > (SAMPLE_BITS+7)'(16'hFFFF))
                peak_cal <= 16'hFFFF;
            else
                peak_cal <= 16'(shf - (SAMPLE_BITS+7)'(gain_ofs));
            rms_mv      <= rnd[FILT_BITS:8] > 17'hFFFF ? 16'hFFFF : rnd[23:8];
            rms_valid   <= seeded_reg;
            rms_updated <= upd_reg;
        end
    end

endmodule

FILE: rtl/differential_peak_rms_meter_unit.sv
// channel   | dir | handshake              | content
// s_axis    | in  | s_axis_tvalid/tready   | tdata: sample_pos, sample_neg
// m_axis    | out | m_axis_tvalid/tready   | tdata: peak_raw, peak_calibrated, rms_mv
// apb       | in  | psel/penable/pwrite    | five calibration and scaling registers
// A plain item writes the window and updates the running peak; every 16th also sums the
// window squares, runs two divides and a square root, and scales and filters the result; a write
// pointer wrap adds a rescan of the window; both divides share one serial divider.
// Reset clears all control state; window contents are undefined until written.
// A result waits in the output register; the next item is taken while it waits.
module differential_peak_rms_meter_unit
    import dprm_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
    parameter int RMS_INTERVAL = RMS_INTERVAL_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [2*SAMPLE_BITS+((8-(2*SAMPLE_BITS)%8)%8)-1:0] s_axis_tdata, // sample_pos, sample_neg
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [SAMPLE_BITS+32+((8-SAMPLE_BITS%8)%8)-1:0] m_axis_tdata, // peak_raw, peak_calibrated, rms_mv
    output logic [1:0]  m_axis_tuser, // rms_valid, rms_updated
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(WINDOW_DEPTH);

    logic [15:0] gmul_reg, gofs_reg, ref_reg, fs_reg;
    logic        cal_reg;
    logic        ovalid_reg;
    logic        idle, out_free, in_fire, wr;
    dprm_cmd_t   cmd;
    dprm_sts_t   sts;
    logic [AW:0] n_cnt;
    logic [AW-1:0] rd_addr;
    logic [SAMPLE_BITS-1:0] peak_raw;
    logic [15:0] peak_cal, rms_mv;
    logic        rms_valid, rms_updated;

    assign pready        = 1'b1;
    assign wr            = psel && penable && pwrite;
    assign s_axis_tready = idle;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !ovalid_reg || m_axis_tready;
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = ($bits(m_axis_tdata))'({rms_mv, peak_cal, peak_raw});
    assign m_axis_tuser  = {rms_updated, rms_valid};

    always_comb
    begin
        case (paddr[4:2])
            3'(REG_GAIN_MULT):  prdata = {16'h0, gmul_reg};
            3'(REG_GAIN_OFS):   prdata = {16'h0, gofs_reg};
            3'(REG_CAL_EN):     prdata = {31'h0, cal_reg};
            3'(REG_REF_MV):     prdata = {16'h0, ref_reg};
            3'(REG_FULL_SCALE): prdata = {16'h0, fs_reg};
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gmul_reg   <= GAIN_MULT_RST;
            gofs_reg   <= '0;
            cal_reg    <= 1'b0;
            ref_reg    <= REF_MV_RST;
            fs_reg     <= FULL_SCALE_RST;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (wr && paddr[1:0] == 2'b00)
            begin
                case (paddr[4:2])
                    3'(REG_GAIN_MULT):  gmul_reg <= pwdata[15:0];
                    3'(REG_GAIN_OFS):   gofs_reg <= pwdata[15:0];
                    3'(REG_CAL_EN):     cal_reg  <= pwdata[0];
                    3'(REG_REF_MV):     ref_reg  <= pwdata[15:0];
                    3'(REG_FULL_SCALE): fs_reg   <= pwdata[15:0];
                    default: ;
                endcase
            end
            if (cmd.finish)
                ovalid_reg <= 1'b1;
            else if (m_axis_tready)
                ovalid_reg <= 1'b0;
        end
    end

    dprm_ctrl #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_free(out_free),
        .sts(sts), .n_cnt(n_cnt), .cmd(cmd), .rd_addr(rd_addr), .idle(idle)
    );

    dprm_dp #(
        .WINDOW_DEPTH(WINDOW_DEPTH), .SAMPLE_BITS(SAMPLE_BITS),
        .RMS_INTERVAL(RMS_INTERVAL)
    ) u_dp (
        .clk(clk), .rst_n(rst_n),
        .sample_pos(s_axis_tdata[SAMPLE_BITS-1:0]),
        .sample_neg(s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .cmd(cmd), .rd_addr(rd_addr),
        .gain_mult(gmul_reg), .gain_ofs(gofs_reg), .cal_en(cal_reg),
        .ref_mv(ref_reg), .full_scale(fs_reg),
        .sts(sts), .n_cnt(n_cnt),
        .peak_raw(peak_raw), .peak_cal(peak_cal), .rms_mv(rms_mv),
        .rms_valid(rms_valid), .rms_updated(rms_updated)
    );

endmodule
